[sv/assert_macros.svh]
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, ignored while reset is held.
`define ACP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ACP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/acp_pkg.sv]
`timescale 1ns / 1ps
package acp_pkg;

  // Line buffer size, line feed included (3..15).
  localparam int unsigned LINE_MAX = 12;
  localparam int unsigned PosW     = $clog2(LINE_MAX + 1);

  localparam logic [7:0] LINE_FEED  = 8'h0A;
  localparam logic [7:0] SEPARATOR  = 8'h3A;
  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] LETTER_A   = 8'h41;
  localparam logic [7:0] LETTER_P   = 8'h50;
  localparam logic [7:0] LETTER_I   = 8'h49;
  localparam logic [7:0] LETTER_D   = 8'h44;

  typedef enum logic [1:0] {
    SEL_SPEED = 2'd0,
    SEL_PROP  = 2'd1,
    SEL_INTEG = 2'd2,
    SEL_DERIV = 2'd3
  } param_sel_e;

  typedef struct packed {
    logic       hit;
    param_sel_e sel;
  } letter_t;

  typedef struct packed {
    logic               emit;
    param_sel_e         sel;
    logic signed [31:0] value;
  } result_t;

  function automatic letter_t letter_code(input logic [7:0] letter);
    letter_t code;
    code.hit = 1'b1;
    code.sel = SEL_SPEED;
    unique case (letter)
      LETTER_A: code.sel = SEL_SPEED;
      LETTER_P: code.sel = SEL_PROP;
      LETTER_I: code.sel = SEL_INTEG;
      LETTER_D: code.sel = SEL_DERIV;
      default:  code.hit = 1'b0;
    endcase
    return code;
  endfunction

endpackage

[sv/acp_line.sv]
`timescale 1ns / 1ps
module acp_line (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic [7:0]      byte_i,
  output acp_pkg::result_t result_o
);

  logic [acp_pkg::PosW-1:0] pos_q, pos_d;
  logic [7:0]               letter_q, letter_d;
  logic                     sep_q, sep_d;
  logic [31:0]              value_q, value_d;
  logic                     ovf_q, ovf_d;

  logic              is_lf;
  logic              full;
  acp_pkg::letter_t  code;
  logic [31:0]       value_x10;

  assign is_lf     = (byte_i == acp_pkg::LINE_FEED);
  assign full      = (pos_q >= acp_pkg::PosW'(acp_pkg::LINE_MAX));
  assign code      = acp_pkg::letter_code(letter_q);
  assign value_x10 = {value_q[28:0], 3'b000} + {value_q[30:0], 1'b0};

  always_comb begin
    result_o.emit  = is_lf && !ovf_q && !full && sep_q && code.hit;
    result_o.sel   = code.sel;
    result_o.value = value_q;
  end

  always_comb begin
    pos_d    = pos_q;
    letter_d = letter_q;
    sep_d    = sep_q;
    value_d  = value_q;
    ovf_d    = ovf_q;
    if (step_i) begin
      if (is_lf) begin
        // end of line: start afresh whatever the outcome
        pos_d    = '0;
        letter_d = '0;
        sep_d    = 1'b0;
        value_d  = '0;
        ovf_d    = 1'b0;
      end else if (full) begin
        // drop the byte, mark the line bad
        ovf_d = 1'b1;
      end else begin
        if (pos_q == acp_pkg::PosW'(0)) begin
          letter_d = byte_i;
        end else if (pos_q == acp_pkg::PosW'(1)) begin
          sep_d = (byte_i == acp_pkg::SEPARATOR);
        end else begin
          value_d = value_x10 + {24'd0, byte_i} - {24'd0, acp_pkg::ASCII_ZERO};
        end
        pos_d = pos_q + acp_pkg::PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      letter_q <= '0;
      sep_q    <= 1'b0;
      value_q  <= '0;
      ovf_q    <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      letter_q <= letter_d;
      sep_q    <= sep_d;
      value_q  <= value_d;
      ovf_q    <= ovf_d;
    end
  end

endmodule

[sv/ascii_parameter_command_parser_top.sv]
`timescale 1ns / 1ps
// Channel   | Direction | Handshake               | Payload
// ----------+-----------+-------------------------+---------------------------------
// rx        | in        | in_valid_i / in_stall_o | rx_byte_i [7:0]
// param     | out       | out_valid_o / out_stall_i | param_select_o [1:0],
//           |           |                         | param_value_o [31:0] signed
//
// One byte per cycle sustained while the result is not stalled; a line feed passes
// the input register and then the result register before its result comes out.
// The line state update (times ten plus digit) is the only logic between them.
// rst_ni clears the line state and both valid flags; no clearing pass.
// A stalled result stalls the source only once the input register is full too,
// so in_stall_o follows out_stall_i combinationally.
module ascii_parameter_command_parser_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         param_select_o,
  output logic signed [31:0] param_value_o
);

  // input register
  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;

  // result register
  logic               out_vld_q, out_vld_d;
  acp_pkg::param_sel_e out_sel_q;
  logic signed [31:0] out_value_q;

  logic             advance;   // processing stage may move on
  logic             take;      // new request enters the input register
  logic             step;      // byte in the input register is consumed
  acp_pkg::result_t result;

  // hold everything only while a finished result waits and is stalled
  assign advance = !(out_vld_q && out_stall_i);
  assign step    = in_vld_q && advance;

  // stall the source only when the input register cannot drain
  assign in_stall_o = in_vld_q && !advance;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (take) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = step && result.emit;
    end
  end

  acp_line u_line (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload: load on acceptance, hold otherwise
  always_ff @(posedge clk_i) begin
    if (take) begin
      in_byte_q <= rx_byte_i;
    end
    if (step && result.emit) begin
      out_sel_q   <= result.sel;
      out_value_q <= result.value;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign param_select_o = out_sel_q;
  assign param_value_o  = out_value_q;

endmodule

[sv/acp_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module acp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  param_select_o,
  input logic [31:0] param_value_o
);

  `ACP_ASSERT(a_out_valid_holds, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "result dropped while stalled")
  `ACP_ASSERT(a_out_payload_holds, clk_i, rst_ni, out_valid_o && out_stall_i |=> $stable(param_select_o) && $stable(param_value_o), "stalled result changed")
  `ACP_ASSERT_ALWAYS(a_stall_cause, clk_i, in_stall_o |-> out_valid_o && out_stall_i, "input stalled without a stalled result")
  `ACP_ASSERT(a_result_has_source, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2), "result without an accepted request")

endmodule

bind ascii_parameter_command_parser_top acp_checker u_acp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .param_select_o (param_select_o),
  .param_value_o  (param_value_o)
);

[sim/testbench.sv]
`timescale 1ns / 1ps
module testbench;

  // Cycles to wait after the last result before a phase change or the end
  // (two-stage pipeline plus margin).
  localparam int unsigned DRAIN_CYCLES = 8;
  // Cycles with work outstanding but no handshake on either side.
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned REPORT_MAX   = 10;

  typedef struct packed {
    acp_pkg::param_sel_e sel;
    logic signed [31:0]  value;
  } param_word_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic               in_stall_o;
  logic [7:0]         rx_byte_i      = 8'h00;
  logic               out_valid_o;
  logic               out_stall_i    = 1'b0;
  logic [1:0]         param_select_o;
  logic signed [31:0] param_value_o;

  ascii_parameter_command_parser_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .param_select_o (param_select_o),
    .param_value_o  (param_value_o)
  );

  always #5 clk_i = ~clk_i;

  // Bytes waiting to be offered, and parameter writes the parser owes us.
  logic [7:0]  tx_bytes[$];
  param_word_t expected_params[$];

  int unsigned fault_count = 0;

  // Idling controls; change them only while the block is idle.
  bit sender_gaps_on     = 1'b1;
  bit receiver_stalls_on = 1'b1;

  // Shadow of the line state.
  logic [3:0]  line_pos;
  logic [7:0]  cmd_letter;
  logic        sep_seen;
  logic [31:0] running_value;
  logic        line_overflow;

  task automatic note_fault(input string msg);
    fault_count++;
    if (fault_count <= REPORT_MAX) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  task automatic clear_line();
    line_pos      = '0;
    cmd_letter    = '0;
    sep_seen      = 1'b0;
    running_value = '0;
    line_overflow = 1'b0;
  endtask

  // Advance the shadow line state by one accepted byte; queue a parameter
  // write when a well-formed line closes.
  task automatic advance_parser(input logic [7:0] rx);
    param_word_t word;
    logic        hit;
    hit = 1'b1;
    word.sel = acp_pkg::SEL_SPEED;
    word.value = running_value;
    if (rx == acp_pkg::LINE_FEED) begin
      if (!line_overflow && line_pos < acp_pkg::LINE_MAX && sep_seen) begin
        case (cmd_letter)
          acp_pkg::LETTER_A: word.sel = acp_pkg::SEL_SPEED;
          acp_pkg::LETTER_P: word.sel = acp_pkg::SEL_PROP;
          acp_pkg::LETTER_I: word.sel = acp_pkg::SEL_INTEG;
          acp_pkg::LETTER_D: word.sel = acp_pkg::SEL_DERIV;
          default:           hit = 1'b0;
        endcase
        if (hit) begin
          expected_params.push_back(word);
        end
      end
      clear_line();
    end else if (line_pos >= acp_pkg::LINE_MAX) begin
      // Buffer full: drop the byte and poison the line.
      line_overflow = 1'b1;
    end else begin
      if (line_pos == 0) begin
        cmd_letter = rx;
      end else if (line_pos == 1) begin
        sep_seen = (rx == acp_pkg::SEPARATOR);
      end else begin
        // Any byte counts as a digit here, wrapping modulo 2^32.
        running_value = running_value * 32'd10 + {24'h0, rx}
                        - {24'h0, acp_pkg::ASCII_ZERO};
      end
      line_pos = line_pos + 4'd1;
    end
  endtask

  // Sender: offer queued bytes in bursts, with gaps between bursts when
  // sender_gaps_on is set. A stalled request is held untouched until it is taken.
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        advance_parser(rx_byte_i);
        void'(tx_bytes.pop_front());
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (tx_bytes.size() != 0) begin
          in_valid_i <= 1'b1;
          rx_byte_i  <= tx_bytes[0];
          if (burst_left != 0) begin
            burst_left--;
          end else if (sender_gaps_on) begin
            // Some bursts run straight into the next one.
            burst_left = $urandom_range(30, 1);
            gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: while receiver_stalls_on is set, alternate runs of stall and flow, with the odd long stall.
  int unsigned stall_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || !receiver_stalls_on) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      stall_left--;
    end else begin
      if (!out_stall_i) begin
        stall_left = ($urandom_range(15) == 0) ? 40 : $urandom_range(7);
      end else begin
        stall_left = $urandom_range(15);
      end
      out_stall_i <= !out_stall_i;
    end
  end

  // Compare every taken result with the oldest outstanding write.
  always @(posedge clk_i) begin : check_results
    param_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_params.size() == 0) begin
        note_fault($sformatf("unexpected result: sel %0d value %0d",
                             param_select_o, param_value_o));
      end else begin
        want = expected_params.pop_front();
        if (param_select_o !== want.sel || param_value_o !== want.value) begin
          note_fault($sformatf("mismatch: expected sel %0d value %0d, got sel %0d value %0d",
                               want.sel, want.value, param_select_o, param_value_o));
        end
      end
    end
  end

  // Give up if work is outstanding but nothing moves for too long.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((tx_bytes.size() != 0 || expected_params.size() != 0) &&
          !(in_valid_i && !in_stall_o) && !(out_valid_o && !out_stall_i)) begin
        quiet_cycles++;
      end else begin
        quiet_cycles = 0;
      end
    end
    $display("ascii_parameter_command_parser_top verification failed");
    $finish;
  end

  // Queue one byte; hold back while four are already waiting.
  task automatic send_byte(input logic [7:0] b);
    while (tx_bytes.size() >= 4) begin
      @(posedge clk_i);
    end
    tx_bytes.push_back(b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i]);
    end
  endtask

  // Wait until every byte is taken and every write has come out.
  task automatic wait_idle();
    while (tx_bytes.size() != 0 || in_valid_i || expected_params.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_each_parameter();
    send_text("A:\n");      // empty value writes zero
    send_text("P:7\n");
    send_text("I:305\n");
    send_text("D:99\n");
  endtask

  task automatic test_byte_extremes();
    // Non-digit bytes at both ends of the range still accumulate.
    send_text("I:");
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(acp_pkg::LINE_FEED);
    // Longest line that still writes, and large enough to wrap.
    send_text("D:");
    repeat (acp_pkg::LINE_MAX - 3) send_byte(8'hFF);
    send_byte(acp_pkg::LINE_FEED);
    send_byte(8'hFF);
    send_text(":1\n");
  endtask

  task automatic test_rejected_lines();
    send_text("\n");        // line feed at position zero
    send_text("A\n");       // line feed at position one
    send_text("B:5\n");     // unknown letter
    send_text("A;5\n");     // wrong separator
    // Line feed lands exactly when the buffer is full.
    send_text("P:");
    repeat (acp_pkg::LINE_MAX - 2) send_byte("1");
    send_byte(acp_pkg::LINE_FEED);
    // Overlong line, then a good one to show the state recovers.
    send_text("P:");
    repeat (acp_pkg::LINE_MAX) send_byte("2");
    send_byte(acp_pkg::LINE_FEED);
    send_text("A:1\n");
  endtask

  // Mostly well-formed lines with random content; the rest damaged,
  // overlong or plain noise.
  task automatic send_random_line(output int unsigned counted);
    int unsigned kind;
    int unsigned len;
    logic [7:0]  letter;
    kind = $urandom_range(99);
    case ($urandom_range(3))
      0:       letter = acp_pkg::LETTER_A;
      1:       letter = acp_pkg::LETTER_P;
      2:       letter = acp_pkg::LETTER_I;
      default: letter = acp_pkg::LETTER_D;
    endcase
    if (kind < 70) begin
      len = $urandom_range(acp_pkg::LINE_MAX - 3);
      send_byte(letter);
      send_byte(acp_pkg::SEPARATOR);
      repeat (len) send_byte(8'(acp_pkg::ASCII_ZERO + $urandom_range(9)));
      send_byte(acp_pkg::LINE_FEED);
      counted = len + 3;
    end else if (kind < 82) begin
      len = $urandom_range(acp_pkg::LINE_MAX - 3);
      send_byte(($urandom_range(1) == 0) ? letter : 8'($urandom_range(255)));
      send_byte(($urandom_range(1) == 0) ? acp_pkg::SEPARATOR : 8'($urandom_range(255)));
      repeat (len) send_byte(8'($urandom_range(255)));
      send_byte(acp_pkg::LINE_FEED);
      counted = len + 3;
    end else if (kind < 90) begin
      len = $urandom_range(acp_pkg::LINE_MAX + 2, acp_pkg::LINE_MAX - 2);
      send_byte(letter);
      send_byte(acp_pkg::SEPARATOR);
      repeat (len) send_byte(8'(acp_pkg::ASCII_ZERO + $urandom_range(9)));
      send_byte(acp_pkg::LINE_FEED);
      // Bytes dropped past the buffer do not count.
      counted = ((len + 2 < acp_pkg::LINE_MAX) ? len + 2 : acp_pkg::LINE_MAX) + 1;
    end else begin
      len = $urandom_range(8, 1);
      repeat (len) send_byte(8'($urandom_range(255)));
      counted = len;
    end
  endtask

  task automatic run_random_lines(input int unsigned target);
    int unsigned total;
    int unsigned counted;
    total = 0;
    while (total < target) begin
      send_random_line(counted);
      total += counted;
    end
    // Close any line left open by noise.
    send_byte(acp_pkg::LINE_FEED);
  endtask

  task automatic test_random_traffic();
    sender_gaps_on     = 1'b1;
    receiver_stalls_on = 1'b1;
    run_random_lines(1100);
  endtask

  task automatic test_back_to_back();
    sender_gaps_on     = 1'b0;
    receiver_stalls_on = 1'b0;
    run_random_lines(350);
  endtask

  initial begin
    clear_line();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_each_parameter();
    test_byte_extremes();
    test_rejected_lines();
    wait_idle();
    test_random_traffic();
    wait_idle();
    test_back_to_back();
    wait_idle();

    if (expected_params.size() != 0) begin
      note_fault($sformatf("%0d results never arrived", expected_params.size()));
    end
    if (fault_count == 0) begin
      $display("ascii_parameter_command_parser_top verification clean");
    end else begin
      $display("ascii_parameter_command_parser_top verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/acp_pkg.sv
sv/acp_line.sv
sv/ascii_parameter_command_parser_top.sv
sv/acp_checker.sv
sim/testbench.sv
